// File: rtl/core/vertex_view_project_unit_defines.svh
// Assertion macros for the vertex projection core.
`ifndef VERTEX_VIEW_PROJECT_UNIT_DEFINES_SVH
`define VERTEX_VIEW_PROJECT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define VVP_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define VVP_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

// Check that also holds across reset.
`define VVP_CHECK_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/vvp_pkg.sv
package vvp_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int TRIG_FRAC = 14;
   localparam int QUOT_BITS = 18;
   localparam int SCREEN_W = 640;
   localparam int SCREEN_H = 360;
   localparam int CENTER_X = SCREEN_W / 2;
   localparam int CENTER_Y = SCREEN_H / 2;
   localparam int FOV_RESET = 500;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CAM_X     = 3'd0,
      REG_CAM_Y     = 3'd1,
      REG_CAM_Z     = 3'd2,
      REG_COS_YAW   = 3'd3,
      REG_SIN_YAW   = 3'd4,
      REG_COS_PITCH = 3'd5,
      REG_SIN_PITCH = 3'd6,
      REG_FOV       = 3'd7
   } vvp_reg_type;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
   } vvp_req_type;

   typedef struct packed {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic signed [31:0] view_depth;
      logic               behind_camera;
   } vvp_rsp_type;

   typedef struct packed {
      logic        behind_camera;
      logic [31:0] view_depth;
   } vvp_side_type;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic ovf_x;
      logic ovf_y;
   } vvp_sign_type;

endpackage

// File: rtl/core/vertex_view_project_unit.sv
// Perspective vertex transform: a world-space Q16.16 vertex is moved into
// camera space, rotated by yaw then pitch (Q2.14 trig registers) and
// projected to saturated 16-bit pixels around the screen centre, with the
// view depth and a behind-camera flag (pixels zero when depth <= 0).
// Fully pipelined, one vertex word per clock when not stalled: six transform
// stages, two divider set-up stages, one stage per quotient bit of the shared
// x/y divider (18) and the output register.
// Bubbles close up under back-pressure. Write the camera registers only
// while the pipe is empty.
`include "vertex_view_project_unit_defines.svh"

module vertex_view_project_unit
   import vvp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  vvp_req_type            req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output vvp_rsp_type            rsp_word,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = COORD_WIDTH;
   localparam int PW = CW + 16;
   localparam int SW = CW + 18;
   localparam int NW = CW + 13;
   localparam int QW = QUOT_BITS + 3;

   localparam logic signed [SW-1:0] CwMax = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [SW-1:0] CwMin = ~CwMax;
   localparam logic signed [SW-1:0] D32Max = {{(SW-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [SW-1:0] D32Min = ~D32Max;
   localparam logic signed [QW-1:0] S16Max = QW'(32767);
   localparam logic signed [QW-1:0] S16Min = ~S16Max;

   function automatic logic signed [CW-1:0] sat_cw(input logic signed [SW-1:0] v);
      logic signed [CW-1:0] r;
      if (v > CwMax) begin
         r = CwMax[CW-1:0];
      end else if (v < CwMin) begin
         r = CwMin[CW-1:0];
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat_32(input logic signed [SW-1:0] v);
      logic signed [31:0] r;
      if (v > D32Max) begin
         r = D32Max[31:0];
      end else if (v < D32Min) begin
         r = D32Min[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat_16(input logic signed [QW-1:0] v);
      logic signed [15:0] r;
      if (v > S16Max) begin
         r = S16Max[15:0];
      end else if (v < S16Min) begin
         r = S16Min[15:0];
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // camera registers
   logic signed [31:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic signed [15:0] cos_yaw_ff, sin_yaw_ff, cos_pitch_ff, sin_pitch_ff;
   logic [11:0]        fov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff     <= '0;
         cam_y_ff     <= '0;
         cam_z_ff     <= 32'sd655360;
         cos_yaw_ff   <= 16'sd16384;
         sin_yaw_ff   <= '0;
         cos_pitch_ff <= 16'sd16384;
         sin_pitch_ff <= '0;
         fov_ff       <= 12'(FOV_RESET);
      end else if (csr_wen) begin
         case (vvp_reg_type'(csr_index))
            REG_CAM_X:     cam_x_ff     <= csr_wdata;
            REG_CAM_Y:     cam_y_ff     <= csr_wdata;
            REG_CAM_Z:     cam_z_ff     <= csr_wdata;
            REG_COS_YAW:   cos_yaw_ff   <= csr_wdata[15:0];
            REG_SIN_YAW:   sin_yaw_ff   <= csr_wdata[15:0];
            REG_COS_PITCH: cos_pitch_ff <= csr_wdata[15:0];
            REG_SIN_PITCH: sin_pitch_ff <= csr_wdata[15:0];
            REG_FOV:       fov_ff       <= csr_wdata[11:0];
            default: begin
            end
         endcase
      end
   end

   // stage valids and per-stage ready chain
   logic [6:1] v_ff;
   logic [6:1] rdy;
   logic       div_in_ready, div_out_valid, out_rdy;

   assign rdy[6]    = !v_ff[6] || div_in_ready;
   assign rdy[5]    = !v_ff[5] || rdy[6];
   assign rdy[4]    = !v_ff[4] || rdy[5];
   assign rdy[3]    = !v_ff[3] || rdy[4];
   assign rdy[2]    = !v_ff[2] || rdy[3];
   assign rdy[1]    = !v_ff[1] || rdy[2];
   assign req_ready = rdy[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[1]) v_ff[1] <= req_valid;
         if (rdy[2]) v_ff[2] <= v_ff[1];
         if (rdy[3]) v_ff[3] <= v_ff[2];
         if (rdy[4]) v_ff[4] <= v_ff[3];
         if (rdy[5]) v_ff[5] <= v_ff[4];
         if (rdy[6]) v_ff[6] <= v_ff[5];
      end
   end

   // stage 1: translate
   logic signed [CW-1:0] tx_ff, ty_ff, tz_ff;
   logic signed [CW-1:0] tx_in, ty_in, tz_in;

   assign tx_in = sat_cw(SW'(req_word.world_x) - SW'(cam_x_ff));
   assign ty_in = sat_cw(SW'(req_word.world_y) - SW'(cam_y_ff));
   assign tz_in = sat_cw(SW'(req_word.world_z) - SW'(cam_z_ff));

   always_ff @(posedge clock) begin
      if (rdy[1] && req_valid) begin
         tx_ff <= tx_in;
         ty_ff <= ty_in;
         tz_ff <= tz_in;
      end
   end

   // stage 2: yaw products
   logic signed [PW-1:0] p_cyx_ff, p_syz_ff, p_cyz_ff, p_syx_ff;
   logic signed [CW-1:0] ty2_ff;

   always_ff @(posedge clock) begin
      if (rdy[2] && v_ff[1]) begin
         p_cyx_ff <= PW'(cos_yaw_ff) * PW'(tx_ff);
         p_syz_ff <= PW'(sin_yaw_ff) * PW'(tz_ff);
         p_cyz_ff <= PW'(cos_yaw_ff) * PW'(tz_ff);
         p_syx_ff <= PW'(sin_yaw_ff) * PW'(tx_ff);
         ty2_ff   <= ty_ff;
      end
   end

   // stage 3: yaw sums; exact sums saturate the same as the 64-bit clamp
   logic signed [CW-1:0] x1_ff, y1_ff, z1_ff;
   logic signed [SW-1:0] sx1_in, sz1_in;

   assign sx1_in = (SW'(p_cyx_ff) + SW'(p_syz_ff)) >>> TRIG_FRAC;
   assign sz1_in = (SW'(p_cyz_ff) - SW'(p_syx_ff)) >>> TRIG_FRAC;

   always_ff @(posedge clock) begin
      if (rdy[3] && v_ff[2]) begin
         x1_ff <= sat_cw(sx1_in);
         y1_ff <= ty2_ff;
         z1_ff <= sat_cw(sz1_in);
      end
   end

   // stage 4: pitch products
   logic signed [PW-1:0] p_cpy_ff, p_spz_ff, p_spy_ff, p_cpz_ff;
   logic signed [CW-1:0] x1b_ff;

   always_ff @(posedge clock) begin
      if (rdy[4] && v_ff[3]) begin
         p_cpy_ff <= PW'(cos_pitch_ff) * PW'(y1_ff);
         p_spz_ff <= PW'(sin_pitch_ff) * PW'(z1_ff);
         p_spy_ff <= PW'(sin_pitch_ff) * PW'(y1_ff);
         p_cpz_ff <= PW'(cos_pitch_ff) * PW'(z1_ff);
         x1b_ff   <= x1_ff;
      end
   end

   // stage 5: pitch sums
   logic signed [CW-1:0] x2_ff, y2_ff, z2_ff;
   logic signed [SW-1:0] sy2_in, sz2_in;

   assign sy2_in = (SW'(p_cpy_ff) - SW'(p_spz_ff)) >>> TRIG_FRAC;
   assign sz2_in = (SW'(p_spy_ff) + SW'(p_cpz_ff)) >>> TRIG_FRAC;

   always_ff @(posedge clock) begin
      if (rdy[5] && v_ff[4]) begin
         x2_ff <= x1b_ff;
         y2_ff <= sat_cw(sy2_in);
         z2_ff <= sat_cw(sz2_in);
      end
   end

   // stage 6: scale by field of view, depth and flag
   logic signed [NW-1:0] nx_ff, ny_ff;
   logic [CW-1:0]        den_ff;
   vvp_side_type         side_ff, side_in;
   logic signed [NW-1:0] fov_in;
   logic                 behind_in;

   assign fov_in    = NW'(signed'({1'b0, fov_ff}));
   assign behind_in = z2_ff[CW-1] || (z2_ff == '0);

   always_comb begin
      side_in.behind_camera = behind_in;
      side_in.view_depth    = sat_32(SW'(z2_ff));
   end

   always_ff @(posedge clock) begin
      if (rdy[6] && v_ff[5]) begin
         nx_ff   <= NW'(x2_ff) * fov_in;
         ny_ff   <= NW'(y2_ff) * fov_in;
         den_ff  <= behind_in ? CW'(1) : z2_ff;
         side_ff <= side_in;
      end
   end

   // divide
   logic [QUOT_BITS-1:0] qx, qy;
   vvp_sign_type         q_sign;
   vvp_side_type         q_side;

   vvp_div #(
      .CoordWidth(CW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v_ff[6]),
      .in_ready  (div_in_ready),
      .in_num_x  (nx_ff),
      .in_num_y  (ny_ff),
      .in_den    (den_ff),
      .in_side   (side_ff),
      .out_valid (div_out_valid),
      .out_ready (out_rdy),
      .out_quot_x(qx),
      .out_quot_y(qy),
      .out_sign  (q_sign),
      .out_side  (q_side)
   );

   // output register: sign, centre, clamp
   logic                 rsp_valid_ff;
   vvp_rsp_type          rsp_ff, rsp_in;
   logic signed [QW-1:0] mx_in, my_in, px_in, py_in;

   assign out_rdy = !rsp_valid_ff || rsp_ready;

   always_comb begin
      mx_in = q_sign.ovf_x ? QW'(2 ** QUOT_BITS) : QW'(qx);
      my_in = q_sign.ovf_y ? QW'(2 ** QUOT_BITS) : QW'(qy);
      px_in = (q_sign.neg_x ? -mx_in : mx_in) + QW'(CENTER_X);
      py_in = (q_sign.neg_y ? -my_in : my_in) + QW'(CENTER_Y);
      rsp_in.view_depth    = q_side.view_depth;
      rsp_in.behind_camera = q_side.behind_camera;
      rsp_in.screen_x      = q_side.behind_camera ? '0 : sat_16(px_in);
      rsp_in.screen_y      = q_side.behind_camera ? '0 : sat_16(py_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && div_out_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `VVP_CHECK(a_behind_zero, rsp_valid_ff && rsp_ff.behind_camera, rsp_ff.screen_x == 16'sd0 && rsp_ff.screen_y == 16'sd0, "behind-camera word has non-zero pixels")
   `VVP_CHECK(a_front_depth, rsp_valid_ff && !rsp_ff.behind_camera, rsp_ff.view_depth > 32'sd0, "in-front word has non-positive depth")
   `VVP_CHECK_NEXT(a_stage_hold, v_ff[6] && !div_in_ready, v_ff[6] && $stable(nx_ff) && $stable(den_ff), "stalled divider input lost")
   `VVP_CHECK_ALWAYS(a_reset_empty, $past(reset) && !reset, !rsp_valid_ff && v_ff == '0, "pipe not empty after reset")

endmodule

// File: rtl/core/vvp_div.sv
module vvp_div
   import vvp_pkg::*;
#(
   parameter int CoordWidth = COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [CoordWidth+12:0] in_num_x,
   input  logic signed [CoordWidth+12:0] in_num_y,
   input  logic [CoordWidth-1:0]         in_den,
   input  vvp_side_type                  in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [QUOT_BITS-1:0]          out_quot_x,
   output logic [QUOT_BITS-1:0]          out_quot_y,
   output vvp_sign_type                  out_sign,
   output vvp_side_type                  out_side
);

   localparam int NW = CoordWidth + 13;
   localparam int MW = NW - 1;
   localparam int CmpW = ((MW > CoordWidth + QUOT_BITS) ? MW : CoordWidth + QUOT_BITS) + 1;

   // magnitude stage
   logic                  a_valid_ff;
   logic [MW-1:0]         a_mag_x_ff, a_mag_y_ff;
   logic [CoordWidth-1:0] a_den_ff;
   vvp_side_type          a_side_ff;
   logic                  a_neg_x_ff, a_neg_y_ff;
   logic                  a_ready;
   logic signed [NW-1:0]  abs_x_in, abs_y_in;

   // step stages: index 0 holds the range check, then one quotient bit each
   logic [QUOT_BITS:0]    v_ff;
   logic [QUOT_BITS:0]    rdy;
   logic [MW-1:0]         rem_x_ff  [0:QUOT_BITS];
   logic [MW-1:0]         rem_y_ff  [0:QUOT_BITS];
   logic [QUOT_BITS-1:0]  q_x_ff    [0:QUOT_BITS];
   logic [QUOT_BITS-1:0]  q_y_ff    [0:QUOT_BITS];
   logic [CoordWidth-1:0] den_ff    [0:QUOT_BITS];
   vvp_sign_type          sign_ff   [0:QUOT_BITS];
   vvp_side_type          side_ff   [0:QUOT_BITS];
   logic [CmpW-1:0]       lim_in;
   vvp_sign_type          sign_in;

   always_comb begin
      rdy[QUOT_BITS] = !v_ff[QUOT_BITS] || out_ready;
      for (int s = QUOT_BITS - 1; s >= 0; s--) begin
         rdy[s] = !v_ff[s] || rdy[s+1];
      end
   end

   assign a_ready  = !a_valid_ff || rdy[0];
   assign in_ready = a_ready;

   assign abs_x_in = in_num_x[NW-1] ? -in_num_x : in_num_x;
   assign abs_y_in = in_num_y[NW-1] ? -in_num_y : in_num_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_mag_x_ff <= abs_x_in[MW-1:0];
         a_mag_y_ff <= abs_y_in[MW-1:0];
         a_neg_x_ff <= in_num_x[NW-1];
         a_neg_y_ff <= in_num_y[NW-1];
         a_den_ff   <= in_den;
         a_side_ff  <= in_side;
      end
   end

   // quotient of 2^QUOT_BITS or more saturates downstream anyway
   assign lim_in = CmpW'(a_den_ff) << QUOT_BITS;
   always_comb begin
      sign_in.neg_x = a_neg_x_ff;
      sign_in.neg_y = a_neg_y_ff;
      sign_in.ovf_x = CmpW'(a_mag_x_ff) >= lim_in;
      sign_in.ovf_y = CmpW'(a_mag_y_ff) >= lim_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         v_ff[0] <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && a_valid_ff) begin
         rem_x_ff[0] <= sign_in.ovf_x ? '0 : a_mag_x_ff;
         rem_y_ff[0] <= sign_in.ovf_y ? '0 : a_mag_y_ff;
         q_x_ff[0]   <= '0;
         q_y_ff[0]   <= '0;
         den_ff[0]   <= a_den_ff;
         sign_ff[0]  <= sign_in;
         side_ff[0]  <= a_side_ff;
      end
   end

   for (genvar s = 1; s <= QUOT_BITS; s++) begin : g_step
      localparam int K = QUOT_BITS - s;
      logic [CmpW-1:0] sub_in;
      logic            ge_x_in, ge_y_in;
      logic [CmpW-1:0] dif_x_in, dif_y_in;

      assign sub_in   = CmpW'(den_ff[s-1]) << K;
      assign ge_x_in  = CmpW'(rem_x_ff[s-1]) >= sub_in;
      assign ge_y_in  = CmpW'(rem_y_ff[s-1]) >= sub_in;
      assign dif_x_in = CmpW'(rem_x_ff[s-1]) - sub_in;
      assign dif_y_in = CmpW'(rem_y_ff[s-1]) - sub_in;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            v_ff[s] <= v_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s] && v_ff[s-1]) begin
            rem_x_ff[s] <= ge_x_in ? dif_x_in[MW-1:0] : rem_x_ff[s-1];
            rem_y_ff[s] <= ge_y_in ? dif_y_in[MW-1:0] : rem_y_ff[s-1];
            q_x_ff[s]   <= q_x_ff[s-1] | (QUOT_BITS'(ge_x_in) << K);
            q_y_ff[s]   <= q_y_ff[s-1] | (QUOT_BITS'(ge_y_in) << K);
            den_ff[s]   <= den_ff[s-1];
            sign_ff[s]  <= sign_ff[s-1];
            side_ff[s]  <= side_ff[s-1];
         end
      end
   end

   assign out_valid  = v_ff[QUOT_BITS];
   assign out_quot_x = q_x_ff[QUOT_BITS];
   assign out_quot_y = q_y_ff[QUOT_BITS];
   assign out_sign   = sign_ff[QUOT_BITS];
   assign out_side   = side_ff[QUOT_BITS];

endmodule
